/* src/llt_pkg.sv */
// ----------------------------------------------------------------------------
// Login lockout table package
// Shared types and constants for the login failure lockout table: verdict
// codes, register indexes, reset values, table entry layout and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_WRONG  = 2'd1,
    VERDICT_LOCKED = 2'd2
  } verdict_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_MS      = 2'd2;

  localparam logic [COUNT_W-1:0] FAILURE_LIMIT_RST = 8'd3;
  localparam logic [TIME_W-1:0]  PENALTY_MS_RST    = 32'd5000;
  localparam logic [TIME_W-1:0]  STALE_MS_RST      = 32'd60000;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'hFF;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  last_fail;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the attempt and restart the scan
    logic scan;    // read the next table entry
    logic decide;  // resolve verdict, write back, load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the entry being read now is the last one
    logic out_busy;   // result register is full and held by the receiver
  } ctrl_status_t;

endpackage

/* src/login_failure_lockout_table_top.sv */
// ----------------------------------------------------------------------------
// Login failure lockout table, top level
// Tracks failed login attempts per client address and returns a verdict of
// accepted, wrong password or locked out for each attempt.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Beat contents
//   -------  ---------  --------------------  ------------------------------------
//   in       input      in_valid / in_stall   client_address, now_ms, password_matches
//   out      output     out_valid / out_stall verdict, entry_assigned
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// The controller takes one attempt at a time: a new beat is accepted only
// once the last one has been decided. The table scan sets the pace: the
// table has one read port, so each entry is read and checked on its own,
// followed by a drain of the last read and then the decision and
// write-back, after which the controller is idle and takes the next beat.
// Reset (rst, synchronous, active high) clears the control state, loads the
// register reset values and clears the per-entry valid bits, so every entry
// reads as all zero until first written. No clearing pass is needed.
// The result register holds a beat while out_stall is high; the next attempt
// is accepted and scanned meanwhile and waits at its decision for the
// register to free up.
// ----------------------------------------------------------------------------
module login_failure_lockout_table_top #(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_write,
  input  logic [llt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [llt_pkg::CFG_W-1:0]     cfg_data,
  // Attempt channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [llt_pkg::ADDR_W-1:0]    client_address,
  input  logic [llt_pkg::TIME_W-1:0]    now_ms,
  input  logic                          password_matches,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    verdict,
  output logic                          entry_assigned
);
  import llt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // The controller owns the sequencing of one attempt; the datapath owns all
  // storage, comparisons and the result register.
  llt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  llt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .client_address   (client_address),
    .now_ms           (now_ms),
    .password_matches (password_matches),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .verdict          (verdict),
    .entry_assigned   (entry_assigned)
  );

endmodule

/* src/llt_ctrl.sv */
// ----------------------------------------------------------------------------
// Login lockout table controller
// Sequences one attempt at a time: accept, scan of the table, a drain of
// the last read, then the decision and write-back.
// ----------------------------------------------------------------------------
module llt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  llt_pkg::ctrl_status_t status,
  output llt_pkg::ctrl_cmd_t    cmd
);
  import llt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.out_busy) begin
          cmd.decide = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

`ifndef ASSERT_OFF
  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_SCAN))
    else $error("start did not lead into the scan");

  a_decide_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> !in_stall)
    else $error("controller did not return to idle after a decision");

  a_drain_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> $past(cmd.scan && status.scan_last))
    else $error("drain entered without a completed scan");
`endif

endmodule

/* src/llt_dpath.sv */
// ----------------------------------------------------------------------------
// Login lockout table datapath
// Holds the configuration registers, the entry table with its valid bits,
// the scan evaluation, the verdict logic and the result register.
// ----------------------------------------------------------------------------
module llt_dpath #(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [llt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [llt_pkg::CFG_W-1:0]         cfg_data,
  input  logic [llt_pkg::ADDR_W-1:0]        client_address,
  input  logic [llt_pkg::TIME_W-1:0]        now_ms,
  input  logic                              password_matches,
  input  llt_pkg::ctrl_cmd_t                cmd,
  output llt_pkg::ctrl_status_t             status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        verdict,
  output logic                              entry_assigned
);
  import llt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Configuration registers.
  logic [COUNT_W-1:0] failure_limit;
  logic [TIME_W-1:0]  penalty_ms;
  logic [TIME_W-1:0]  stale_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_limit <= FAILURE_LIMIT_RST;
      penalty_ms    <= PENALTY_MS_RST;
      stale_ms      <= STALE_MS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FAILURE_LIMIT: failure_limit <= cfg_data[COUNT_W-1:0];
        CFG_PENALTY_MS:    penalty_ms    <= cfg_data[TIME_W-1:0];
        CFG_STALE_MS:      stale_ms      <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Latched attempt.
  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] now_q;
  logic              pass_q;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_q <= client_address;
      now_q  <= now_ms;
      pass_q <= password_matches;
    end
  end

  // Entry table: one write and one registered read per cycle. An entry that
  // was never written reads as all zero through its valid bit.
  entry_t             table_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ent_vld;
  logic [IDX_W-1:0]   scan_idx;
  entry_t             rd_raw;
  logic               rd_raw_vld;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_idx] <= wr_entry;
    end
    if (cmd.scan) begin
      rd_raw     <= table_mem[scan_idx];
      rd_raw_vld <= ent_vld[scan_idx];
      rd_idx_q   <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (mem_we) begin
      ent_vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd.scan;
      if (cmd.start) begin
        scan_idx <= '0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  assign status.scan_last = (scan_idx == IDX_W'(TABLE_ENTRIES - 1));

  // Scan evaluation: first address match, and first free or stale entry.
  entry_t            rd_ent;
  logic [TIME_W-1:0] rd_age;
  logic              rd_hit;
  logic              rd_free;

  assign rd_ent  = rd_raw_vld ? rd_raw : '0;
  assign rd_age  = now_q - rd_ent.last_fail;
  assign rd_hit  = (rd_ent.addr == addr_q);
  assign rd_free = (rd_ent.count == '0) || (rd_age > stale_ms);

  logic               found_m;
  logic               found_c;
  logic [IDX_W-1:0]   m_idx;
  logic [IDX_W-1:0]   c_idx;
  logic [COUNT_W-1:0] m_count;
  logic [TIME_W-1:0]  m_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      found_m <= 1'b0;
      found_c <= 1'b0;
    end else if (cmd.start) begin
      found_m <= 1'b0;
      found_c <= 1'b0;
    end else if (rd_vld_q) begin
      if (!found_m && rd_hit) begin
        found_m <= 1'b1;
      end
      if (!found_c && rd_free) begin
        found_c <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_q && !found_m && rd_hit) begin
      m_idx   <= rd_idx_q;
      m_count <= rd_ent.count;
      m_last  <= rd_ent.last_fail;
    end
    if (rd_vld_q && !found_c && rd_free) begin
      c_idx <= rd_idx_q;
    end
  end

  // Decision. A claimed entry starts from a zero count and time.
  logic               slot_ok;
  logic [COUNT_W-1:0] cur_count;
  logic [TIME_W-1:0]  cur_last;
  logic [TIME_W-1:0]  since;
  logic               locked;
  verdict_t           verdict_d;

  assign slot_ok   = found_m || found_c;
  assign cur_count = found_m ? m_count : '0;
  assign cur_last  = found_m ? m_last : '0;
  assign since     = now_q - cur_last;
  assign locked    = slot_ok && (cur_count >= failure_limit) && (since < penalty_ms);

  always_comb begin
    wr_entry.addr = addr_q;
    if (locked) begin
      verdict_d          = VERDICT_LOCKED;
      wr_entry.count     = cur_count;
      wr_entry.last_fail = cur_last;
    end else if (pass_q) begin
      verdict_d          = VERDICT_OK;
      wr_entry.count     = '0;
      wr_entry.last_fail = '0;
    end else begin
      verdict_d          = VERDICT_WRONG;
      wr_entry.count     = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
      wr_entry.last_fail = now_q;
    end
  end

  assign wr_idx = found_m ? m_idx : c_idx;
  assign mem_we = cmd.decide && slot_ok;

  // Result register.
  verdict_t verdict_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      verdict_q      <= verdict_d;
      entry_assigned <= slot_ok;
    end
  end

  assign verdict         = verdict_q;
  assign status.out_busy = out_valid && out_stall;

`ifndef ASSERT_OFF
  a_read_follows_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld_q |-> $past(cmd.scan))
    else $error("table read data marked valid without a scan read");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !(out_valid && out_stall))
    else $error("decision overwrote a held result");

  a_locked_is_tracked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (verdict_q == VERDICT_LOCKED)) |-> entry_assigned)
    else $error("lockout reported without a tracking entry");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> ent_vld[$past(wr_idx)])
    else $error("written entry not marked valid");
`endif

endmodule

/* tb/sv/tb_login_failure_lockout_table_top.sv */
// ----------------------------------------------------------------------------
// Login failure lockout table testbench
// Drives login attempts into the lockout table, predicts every verdict with a
// cycle-free model of the table, and checks each result beat field by field.
// Covers the reset-time address-zero entries, lockout at and past the penalty
// edge, time wrap, table exhaustion, saturation of the failure count, limit
// zero, ignored register writes, and random traffic under several settings.
// ----------------------------------------------------------------------------
module tb_login_failure_lockout_table_top;
  import llt_pkg::*;

  localparam int LOCK_ENTRIES = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  // Index 3 decodes to no register; a write there must leave the table alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [ADDR_W-1:0] SAT_ADDR = 32'hC0A8_0001;

  // One login attempt as it crosses the input channel.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic              pass_ok;
  } attempt_t;

  // What the table should answer for one attempt.
  typedef struct packed {
    verdict_t code;
    logic     tracked;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_W-1:0]    client_address = '0;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 password_matches = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           verdict;
  logic                 entry_assigned;

  // Predicted copy of the table and its registers.
  logic [ADDR_W-1:0]  lock_addr  [LOCK_ENTRIES];
  logic [COUNT_W-1:0] lock_fails [LOCK_ENTRIES];
  logic [TIME_W-1:0]  lock_stamp [LOCK_ENTRIES];
  logic [COUNT_W-1:0] limit_cfg;
  logic [TIME_W-1:0]  penalty_cfg;
  logic [TIME_W-1:0]  stale_cfg;

  attempt_t pending_attempts[$];
  outcome_t verdicts_due[$];
  attempt_t next_attempt;
  outcome_t oldest_due;

  logic [ADDR_W-1:0] client_pool [8];
  logic [TIME_W-1:0] sim_clock_ms;
  int                last_pick;

  int  mismatches = 0;
  int  results_seen = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  pressure_left = 0;
  bit  pressure_done = 1'b0;
  bit  idle_on = 1'b1;
  int  quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  login_failure_lockout_table_top #(
    .TABLE_ENTRIES(LOCK_ENTRIES)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .client_address   (client_address),
    .now_ms           (now_ms),
    .password_matches (password_matches),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .verdict          (verdict),
    .entry_assigned   (entry_assigned)
  );

  // Predict the verdict for one attempt and update the table copy the same
  // way the hardware is meant to: address match first, then the first free
  // or stale entry is claimed and wiped, then lockout, then the password.
  function automatic outcome_t judge_attempt(attempt_t a);
    int slot;
    int k;
    logic [TIME_W-1:0] age;
    outcome_t o;
    slot = -1;
    for (k = 0; k < LOCK_ENTRIES; k++) begin
      if (slot < 0 && lock_addr[k] == a.addr) slot = k;
    end
    for (k = 0; k < LOCK_ENTRIES; k++) begin
      age = a.now - lock_stamp[k];
      if (slot < 0 && (lock_fails[k] == '0 || age > stale_cfg)) begin
        slot = k;
        lock_addr[k] = a.addr;
        lock_fails[k] = '0;
        lock_stamp[k] = '0;
      end
    end
    if (slot < 0) begin
      // No entry to be had: only the password counts.
      o.code = a.pass_ok ? VERDICT_OK : VERDICT_WRONG;
      o.tracked = 1'b0;
    end else begin
      age = a.now - lock_stamp[slot];
      o.tracked = 1'b1;
      if (lock_fails[slot] >= limit_cfg && age < penalty_cfg) begin
        o.code = VERDICT_LOCKED;
      end else if (a.pass_ok) begin
        o.code = VERDICT_OK;
        lock_fails[slot] = '0;
        lock_stamp[slot] = '0;
      end else begin
        o.code = VERDICT_WRONG;
        if (lock_fails[slot] != COUNT_MAX) lock_fails[slot] = lock_fails[slot] + COUNT_W'(1);
        lock_stamp[slot] = a.now;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
    $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, seen, wanted);
    mismatches++;
  endtask

  // Register writes happen only while the table is idle, so the predicted
  // registers can be updated together with the write itself.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_FAILURE_LIMIT: limit_cfg = value[COUNT_W-1:0];
      CFG_PENALTY_MS:    penalty_cfg = value;
      CFG_STALE_MS:      stale_cfg = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_attempt(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] at_ms,
                               logic pass_ok);
    attempt_t a;
    a.addr = addr;
    a.now = at_ms;
    a.pass_ok = pass_ok;
    pending_attempts.push_back(a);
  endtask

  // Mostly well-formed traffic: a small set of clients, time moving forward in
  // short steps and runs of attempts from one client so that lockouts build
  // up. About one attempt in seven is noise over the full field ranges.
  task automatic queue_random_attempts(int count);
    int pick;
    repeat (count) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_attempt($urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 40) == 0)
          sim_clock_ms = $urandom_range(0, 1) ? $urandom
                                             : (32'hFFFF_FFC0 | $urandom_range(0, 63));
        else
          sim_clock_ms = sim_clock_ms + $urandom_range(0, 40);
        pick = $urandom_range(0, 1) ? last_pick : $urandom_range(0, 7);
        last_pick = pick;
        queue_attempt(client_pool[pick], sim_clock_ms, $urandom_range(0, 2) == 0);
      end
    end
  endtask

  // Sampled at the falling edge, away from the updates made at the rising one.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_attempts.size() != 0 || in_valid || verdicts_due.size() != 0);
  endtask

  // Attempt driver. A beat is presented from the pending queue and held
  // unchanged while the table stalls it. Between beats the driver may go
  // quiet for a random burst; when idling is switched off it never does.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdicts_due.push_back(judge_attempt({client_address, now_ms, password_matches}));
      end
      if (in_valid && in_stall) begin
        // Hold the stalled beat as it is.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_attempts.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 15) - 1;
        in_valid <= 1'b0;
      end else begin
        next_attempt = pending_attempts.pop_front();
        in_valid <= 1'b1;
        client_address <= next_attempt.addr;
        now_ms <= next_attempt.now;
        password_matches <= next_attempt.pass_ok;
      end
    end
  end

  // Result monitor. Every accepted result beat is checked against the oldest
  // prediction. The stall is raised in random bursts, and once, after a few
  // hundred results, for a long stretch so that the result register stays
  // full, the next attempt waits at its decision and the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          report_mismatch("result beat with no attempt due, verdict", 32'(verdict), '0);
        end else begin
          oldest_due = verdicts_due.pop_front();
          if (verdict !== oldest_due.code)
            report_mismatch("verdict", 32'(verdict), 32'(oldest_due.code));
          if (entry_assigned !== oldest_due.tracked)
            report_mismatch("entry_assigned", 32'(entry_assigned),
                            32'(oldest_due.tracked));
        end
      end
      if (!pressure_done && results_seen >= 400) begin
        pressure_done = 1'b1;
        pressure_left = 120;
      end
      if (pressure_left > 0) begin
        pressure_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel and no
  // register is written. A hung table ends the run as a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("login_failure_lockout_table_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence. Each phase queues its attempts, waits until every
  // predicted result has come back, and only then touches the registers.
  initial begin
    logic [7:0]  phase_limit   [5];
    logic [31:0] phase_penalty [5];
    logic [31:0] phase_stale   [5];
    int p;
    int k;
    limit_cfg = FAILURE_LIMIT_RST;
    penalty_cfg = PENALTY_MS_RST;
    stale_cfg = STALE_MS_RST;
    for (k = 0; k < LOCK_ENTRIES; k++) begin
      lock_addr[k] = '0;
      lock_fails[k] = '0;
      lock_stamp[k] = '0;
    end
    client_pool[0] = 32'h0000_0000;
    client_pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < 8; k++) client_pool[k] = $urandom;
    last_pick = 0;
    phase_limit   = '{8'd3, 8'd1, 8'd0, 8'd2, 8'($urandom_range(1, 6))};
    phase_penalty = '{32'd60, 32'd25, 32'd10, 32'd0, 32'($urandom_range(0, 100))};
    phase_stale   = '{32'd400, 32'd80, 32'd30, 32'd0, 32'($urandom_range(0, 500))};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings. Every entry holds address zero after reset, so the
    // first attempt from address zero finds an entry by address.
    queue_attempt(32'h0000_0000, 32'd0, 1'b1);
    queue_attempt(32'h0000_0000, 32'd10, 1'b0);
    queue_attempt(32'h0000_0000, 32'd20, 1'b0);
    queue_attempt(32'h0000_0000, 32'd30, 1'b0);
    // Third failure reached: locked out even with the right password.
    queue_attempt(32'h0000_0000, 32'd40, 1'b1);
    // Exactly the penalty has gone by since the last failure: accepted.
    queue_attempt(32'h0000_0000, 32'd5030, 1'b1);
    // Four new clients fill the whole table.
    queue_attempt(32'hFFFF_FFFF, 32'd100, 1'b0);
    queue_attempt(32'h1234_5678, 32'd100, 1'b0);
    queue_attempt(32'hA5A5_A5A5, 32'd100, 1'b0);
    queue_attempt(32'h5A5A_5A5A, 32'd100, 1'b0);
    // Table full and nothing stale: untracked, the password alone decides.
    queue_attempt(32'h0A00_0001, 32'd200, 1'b0);
    queue_attempt(32'h0A00_0001, 32'd200, 1'b1);
    queue_attempt(32'h0000_0000, 32'd200, 1'b1);
    // Lockout that straddles the wrap of the millisecond counter.
    queue_attempt(32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
    queue_attempt(32'hFFFF_FFFF, 32'hFFFF_FFF8, 1'b0);
    queue_attempt(32'hFFFF_FFFF, 32'h0000_0010, 1'b1);
    // Long after: other entries have gone stale and one is reclaimed.
    queue_attempt(32'h0B00_0002, 32'h0001_0000, 1'b1);
    wait_drained();

    // Failure limit zero, longest penalty, no stale grace, and a write to the
    // unused index that must change nothing.
    write_reg(CFG_FAILURE_LIMIT, 32'd0);
    write_reg(CFG_PENALTY_MS, 32'hFFFF_FFFF);
    write_reg(CFG_STALE_MS, 32'd0);
    write_reg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);
    @(negedge clk);
    queue_attempt(32'h7F00_0001, 32'd1000, 1'b1);
    queue_attempt(32'h7F00_0001, 32'd1000, 1'b0);
    queue_attempt(32'h7F00_0001, 32'hFFFF_FFFF, 1'b1);
    queue_attempt(32'h8000_0000, 32'h8000_0000, 1'b0);
    wait_drained();

    // Saturation: with no penalty nothing locks, so one client piles up more
    // than 255 failures. Then the longest penalty and the top limit must lock
    // it, which only holds if the count stuck at its maximum.
    write_reg(CFG_FAILURE_LIMIT, 32'd255);
    write_reg(CFG_PENALTY_MS, 32'd0);
    @(negedge clk);
    sim_clock_ms = 32'h0002_0000;
    repeat (260) begin
      sim_clock_ms = sim_clock_ms + $urandom_range(1, 3);
      queue_attempt(SAT_ADDR, sim_clock_ms, 1'b0);
    end
    wait_drained();
    write_reg(CFG_PENALTY_MS, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_attempt(SAT_ADDR, sim_clock_ms + 32'd1, 1'b1);
    wait_drained();

    // Random phases, each under its own settings. The last one runs with no
    // idling on either side.
    sim_clock_ms = $urandom;
    for (p = 0; p < 5; p++) begin
      write_reg(CFG_FAILURE_LIMIT, {24'd0, phase_limit[p]});
      write_reg(CFG_PENALTY_MS, phase_penalty[p]);
      write_reg(CFG_STALE_MS, phase_stale[p]);
      @(negedge clk);
      if (p == 4) idle_on = 1'b0;
      queue_random_attempts(220);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("login_failure_lockout_table_top regression: pass");
    end else begin
      $display("login_failure_lockout_table_top regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/llt_pkg.sv
src/llt_ctrl.sv
src/llt_dpath.sv
src/login_failure_lockout_table_top.sv
tb/sv/tb_login_failure_lockout_table_top.sv
